// ===== hw/rtl/arc_pkg.sv =====
// Shared constants, types and arctangent table for the refraction corrector.
`timescale 1ns / 1ps

package arc_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int HW           = 28;   // internal altitude width, signed
  localparam int CW           = 34;   // CORDIC and angle width, signed
  localparam int DW           = 64;   // dividend / product width
  localparam int VW           = 42;   // divisor width

  localparam logic [DW-1:0] PI_Q30   = 64'd3373259426;
  localparam logic [31:0]   PI_HALF  = 32'd1686629713;
  localparam logic [31:0]   PI4_Q30  = 32'd843314857;
  // 180 * 2^24 = 45 * 2^26: shift by 26, then divide by 45 via reciprocal
  localparam logic [31:0]   RECIP45  = 32'd95443717;   // floor(2^32 / 45)
  localparam logic [DW-1:0] D45      = 64'd45;
  localparam logic [VW:0]   D45_R    = 43'd45;
  localparam logic signed [CW-1:0] C511 = 34'sd85731574;
  localparam logic [DW-1:0] C103_NUM = 64'd172805325 << 24;
  localparam logic signed [43:0] HD_MIN = -44'sd67108864;
  localparam logic signed [43:0] HD_MAX = 44'sd2181038080;

  localparam logic [0:0] REG_CRIT = 1'b0;

  typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

  // Restoring unsigned division, used only while building constants
  function automatic logic [63:0] udiv_c(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q30 from a truncated series in Q62
  function automatic atan_tab_t atan_table();
    atan_tab_t t;
    logic signed [63:0] sum;
    logic [63:0] term;
    int p;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        t[i] = PI4_Q30;
      end else begin
        sum = '0;
        for (int k = 0; k < 32; k++) begin
          p = 62 - i * (2 * k + 1);
          if (p >= 0) begin
            term = udiv_c(64'd1 << p, 64'(2 * k + 1));
            if (k[0]) begin
              sum = sum - $signed(term);
            end else begin
              sum = sum + $signed(term);
            end
          end
        end
        t[i] = 32'((sum + 64'sd2147483648) >>> 32);
      end
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/atmospheric_refraction_correct_core.sv =====
// Refraction corrector: sequencer around a serial multiplier, divider and CORDIC.
`timescale 1ns / 1ps

// Channel  | Ports                                   | Direction
// in       | in_valid, in_ready, in_cmd, in_altitude_in | item in
// out      | out_valid, out_ready, out_altitude_out, out_not_converged | result out
// cfg      | APB write/read of critical_altitude at byte address 0 | config
//
// One correction runs two 64-bit divisions, two 32-bit multiplies, a quotient fix-up
// and 30 CORDIC rotations; a linear-branch correction runs one multiply and one division.
// Forward items take the critical correction plus one correction;
// inverse items take the critical correction plus up to MAX_ITER corrections.
// in_ready is high only while idle; a result holds on out_* until its beat is taken.
// rst_n is synchronous; it clears the sequencer and restores critical_altitude.

module atmospheric_refraction_correct_core #(
  parameter int MAX_ITER  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic signed [23:0] in_altitude_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [23:0] out_altitude_out,
  output logic        out_not_converged,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int HW = arc_pkg::HW;
  localparam int CW = arc_pkg::CW;
  localparam int DW = arc_pkg::DW;
  localparam int VW = arc_pkg::VW;
  localparam int SH = 24 - FRAC_BITS;
  localparam int NW = $clog2(MAX_ITER + 1);
  localparam longint ONE_F = 64'sd1 << FRAC_BITS;
  localparam longint TOL_L = (ONE_F + 5000) / 10000;
  localparam logic signed [CW-1:0] TOL_V    = CW'(TOL_L);
  localparam logic signed [CW-1:0] F90      = CW'(90 * ONE_F);
  localparam logic signed [CW-1:0] CRIT_MIN = CW'(-4 * ONE_F);
  localparam logic signed [CW-1:0] CRIT_MAX = CW'(90 * ONE_F);
  localparam logic [23:0] CRIT_RST = 24'(-ONE_F);
  localparam logic [NW-1:0] LAST_ITER = NW'(MAX_ITER - 1);
  localparam logic signed [HW-1:0] OUT_MIN = -HW'(28'sd8388608);
  localparam logic signed [HW-1:0] OUT_MAX = HW'(28'sd8388607);
  localparam arc_pkg::atan_tab_t ATAN = arc_pkg::atan_table();

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000000000000001,
    S_HD    = 16'b0000000000000010,
    S_DIV   = 16'b0000000000000100,
    S_Q     = 16'b0000000000001000,
    S_MUL   = 16'b0000000000010000,
    S_XR0   = 16'b0000000000100000,
    S_XR    = 16'b0000000001000000,
    S_ROT   = 16'b0000000010000000,
    S_FIN   = 16'b0000000100000000,
    S_CEND  = 16'b0000001000000000,
    S_DELTA = 16'b0000010000000000,
    S_LDIV  = 16'b0000100000000000,
    S_APPLY = 16'b0001000000000000,
    S_OUT   = 16'b0010000000000000,
    S_XRC   = 16'b0100000000000000,
    S_XRF   = 16'b1000000000000000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [23:0] crit_reg_r;
  logic cmd_r, cmd_nxt, neg_r, neg_nxt, sign_r, sign_nxt, ccph_r, ccph_nxt;
  logic signed [HW-1:0] alt_r, alt_nxt, h0_r, h0_nxt, harg_r, harg_nxt;
  logic signed [HW-1:0] crit_r, crit_nxt, cc_r, cc_nxt, delta_r, delta_nxt;
  logic signed [CW-1:0] hd_r, hd_nxt, cx_r, cx_nxt, cy_r, cy_nxt, z_r, z_nxt;
  logic [DW-1:0] dq_r, dq_nxt, mc_r, mc_nxt, prod_r, prod_nxt;
  logic [31:0] mp_r, mp_nxt;
  logic [VW:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [4:0] rot_r, rot_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic signed [23:0] oalt_r, oalt_nxt;
  logic onc_r, onc_nxt;

  // Working values of the sequencer steps
  logic signed [CW-1:0] crit_c, hp, lin_d, qsum, dx, dy, at, cxn, step, cq, cv;
  logic signed [43:0] hs, hd_c;
  logic [CW-1:0] mag;
  logic [VW:0] tr;
  logic ge;
  logic [VW-1:0] dd;
  logic [31:0] xr;
  logic [DW-1:0] xe, xrm;
  logic signed [HW-1:0] res, h1, rsat;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_reg_r <= CRIT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == arc_pkg::REG_CRIT)) begin
      crit_reg_r <= cfg_pwdata[23:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'($signed(crit_reg_r));

  // Sequencer and shared datapath
  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;   cmd_nxt = cmd_r;   neg_nxt = neg_r;
    sign_nxt = sign_r;    ccph_nxt = ccph_r; alt_nxt = alt_r;   h0_nxt = h0_r;
    harg_nxt = harg_r;    crit_nxt = crit_r; cc_nxt = cc_r;     delta_nxt = delta_r;
    hd_nxt = hd_r;        cx_nxt = cx_r;     cy_nxt = cy_r;     z_nxt = z_r;
    dq_nxt = dq_r;        mc_nxt = mc_r;     prod_nxt = prod_r; mp_nxt = mp_r;
    rem_nxt = rem_r;      dvs_nxt = dvs_r;   cnt_nxt = cnt_r;   rot_nxt = rot_r;
    n_nxt = n_r;          oalt_nxt = oalt_r; onc_nxt = onc_r;

    crit_c = CW'($signed(crit_reg_r));
    if (crit_c < CRIT_MIN) crit_c = CRIT_MIN;
    if (crit_c > CRIT_MAX) crit_c = CRIT_MAX;
    hs = 44'(harg_r) <<< SH;
    hd_c = hs;
    if (hs < arc_pkg::HD_MIN) hd_c = arc_pkg::HD_MIN;
    if (hs > arc_pkg::HD_MAX) hd_c = arc_pkg::HD_MAX;
    tr    = {rem_r[VW-1:0], dq_r[DW-1]};
    ge    = tr >= {1'b0, dvs_r};
    qsum  = hd_r + $signed({2'b00, dq_r[31:0]});
    xr    = dq_r[31:0];
    xe    = prod_r >> 32;
    xrm   = dq_r - xe * arc_pkg::D45;
    dx    = cy_r >>> rot_r;
    dy    = cx_r >>> rot_r;
    at    = $signed({2'b00, ATAN[rot_r]});
    cxn   = neg_r ? -cx_r : cx_r;
    mag   = cxn[CW-1] ? CW'(-cxn) : CW'(cxn);
    dd    = VW'(cy_r) * VW'(1000);
    hp    = CW'(h0_r) + F90;
    lin_d = CW'(crit_r) + F90;
    cq    = $signed({{(CW-HW+1){1'b0}}, dq_r[HW-2:0]});
    cv    = sign_r ? -cq : cq;
    res   = alt_r + delta_r;
    h1    = alt_r - delta_r;
    step  = CW'(h1) - CW'(h0_r);
    if (step < 0) step = -step;
    rsat  = cmd_r ? h1 : res;
    if (rsat < OUT_MIN) rsat = OUT_MIN;
    if (rsat > OUT_MAX) rsat = OUT_MAX;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          alt_nxt   = HW'(in_altitude_in);
          crit_nxt  = HW'(crit_c);
          harg_nxt  = HW'(crit_c);
          ccph_nxt  = 1'b1;
          n_nxt     = '0;
          state_nxt = S_HD;
        end
      end
      // Clamp the angle and start q = C103 / (h + C511)
      S_HD: begin
        hd_nxt    = CW'(hd_c);
        dq_nxt    = arc_pkg::C103_NUM;
        rem_nxt   = '0;
        dvs_nxt   = VW'(CW'(hd_c) + arc_pkg::C511);
        cnt_nxt   = 6'd63;
        ret_nxt   = S_Q;
        state_nxt = S_DIV;
      end
      // One quotient bit per cycle
      S_DIV: begin
        dq_nxt  = {dq_r[DW-2:0], ge};
        rem_nxt = ge ? (tr - {1'b0, dvs_r}) : tr;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_nxt = ret_r;
      end
      S_Q: begin
        mp_nxt    = qsum[31:0];
        mc_nxt    = arc_pkg::PI_Q30;
        prod_nxt  = '0;
        cnt_nxt   = 6'd31;
        ret_nxt   = S_XR0;
        state_nxt = S_MUL;
      end
      // One multiplier bit per cycle
      S_MUL: begin
        if (mp_r[0]) prod_nxt = prod_r + mc_r;
        mc_nxt  = {mc_r[DW-2:0], 1'b0};
        mp_nxt  = {1'b0, mp_r[31:1]};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_nxt = ret_r;
      end
      // Drop 26 bits, then estimate the quotient by 45 with a reciprocal
      S_XR0: begin
        dq_nxt    = prod_r >> 26;
        mc_nxt    = prod_r >> 26;
        mp_nxt    = arc_pkg::RECIP45;
        prod_nxt  = '0;
        cnt_nxt   = 6'd31;
        ret_nxt   = S_XRC;
        state_nxt = S_MUL;
      end
      // Take the estimate, which never exceeds the true quotient
      S_XRC: begin
        dq_nxt    = xe;
        rem_nxt   = xrm[VW:0];
        state_nxt = S_XRF;
      end
      // Advance the quotient until the remainder is below 45
      S_XRF: begin
        if (rem_r >= arc_pkg::D45_R) begin
          rem_nxt = rem_r - arc_pkg::D45_R;
          dq_nxt  = dq_r + DW'(1);
        end else begin
          state_nxt = S_XR;
        end
      end
      // Fold the angle into the first quadrant
      S_XR: begin
        if (xr > arc_pkg::PI_HALF) begin
          z_nxt   = CW'(arc_pkg::PI_Q30) - $signed({2'b00, xr});
          neg_nxt = 1'b1;
        end else begin
          z_nxt   = $signed({2'b00, xr});
          neg_nxt = 1'b0;
        end
        cx_nxt    = CW'(34'sd1073741824);
        cy_nxt    = '0;
        rot_nxt   = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (!z_r[CW-1]) begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          z_nxt  = z_r - at;
        end else begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          z_nxt  = z_r + at;
        end
        rot_nxt = rot_r + 5'd1;
        if (rot_r == 5'(arc_pkg::CORDIC_STEPS - 1)) state_nxt = S_FIN;
      end
      // Start 17 * cx / (1000 * cy), rounded half away from zero; zero when cy <= 0
      S_FIN: begin
        if (cy_r <= 0) begin
          dq_nxt    = '0;
          sign_nxt  = 1'b0;
          state_nxt = S_CEND;
        end else begin
          sign_nxt  = cxn[CW-1];
          dq_nxt    = ((DW'(mag) * DW'(17)) << FRAC_BITS) + DW'(dd >> 1);
          dvs_nxt   = dd;
          rem_nxt   = '0;
          cnt_nxt   = 6'd63;
          ret_nxt   = S_CEND;
          state_nxt = S_DIV;
        end
      end
      S_CEND: begin
        if (ccph_r) begin
          cc_nxt    = HW'(cv);
          ccph_nxt  = 1'b0;
          h0_nxt    = alt_r;
          state_nxt = S_DELTA;
        end else begin
          delta_nxt = HW'(cv);
          state_nxt = S_APPLY;
        end
      end
      // Pick the formula or the linear extrapolation
      S_DELTA: begin
        if (h0_r > crit_r) begin
          harg_nxt  = h0_r;
          state_nxt = S_HD;
        end else begin
          mc_nxt    = DW'(hp[CW-1] ? CW'(-hp) : hp);
          mp_nxt    = 32'(cc_r[HW-1] ? HW'(-cc_r) : cc_r);
          sign_nxt  = hp[CW-1] ^ cc_r[HW-1];
          prod_nxt  = '0;
          cnt_nxt   = 6'd31;
          ret_nxt   = S_LDIV;
          state_nxt = S_MUL;
        end
      end
      S_LDIV: begin
        dq_nxt    = prod_r + DW'(lin_d[CW-2:0] >> 1);
        dvs_nxt   = VW'(lin_d[CW-2:0]);
        rem_nxt   = '0;
        cnt_nxt   = 6'd63;
        ret_nxt   = S_CEND;
        state_nxt = S_DIV;
      end
      // Finish forward items, or test the inverse step
      S_APPLY: begin
        oalt_nxt = 24'(rsat);
        onc_nxt  = 1'b0;
        if (!cmd_r || step <= TOL_V) begin
          state_nxt = S_OUT;
        end else if (n_r == LAST_ITER) begin
          onc_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          h0_nxt    = h1;
          n_nxt     = n_r + NW'(1);
          state_nxt = S_DELTA;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      ccph_r  <= 1'b0;
      n_r     <= '0;
      cnt_r   <= '0;
      rot_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      ccph_r  <= ccph_nxt;
      n_r     <= n_nxt;
      cnt_r   <= cnt_nxt;
      rot_r   <= rot_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;   neg_r <= neg_nxt;     sign_r <= sign_nxt;
    alt_r <= alt_nxt;   h0_r <= h0_nxt;       harg_r <= harg_nxt;
    crit_r <= crit_nxt; cc_r <= cc_nxt;       delta_r <= delta_nxt;
    hd_r <= hd_nxt;     cx_r <= cx_nxt;       cy_r <= cy_nxt;
    z_r <= z_nxt;       dq_r <= dq_nxt;       mc_r <= mc_nxt;
    prod_r <= prod_nxt; mp_r <= mp_nxt;       rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;   oalt_r <= oalt_nxt;   onc_r <= onc_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_OUT);
  assign out_altitude_out  = oalt_r;
  assign out_not_converged = onc_r;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("result beat while taking input");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("input taken twice");
  a_fwd_converged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_not_converged) |-> cmd_r) else $error("forward flagged");
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> (rot_r < 5'(arc_pkg::CORDIC_STEPS)))
    else $error("rotation index out of range");
`endif

endmodule
